/* hdl/frm_pkg.sv */
package frm_pkg;

    // Field widths of one flow record.
    localparam int SEC_W  = 32;
    localparam int USEC_W = 20;
    localparam int MANT_W = 32;
    localparam int EXP_W  = 4;

    // A count expanded by its exponent is at most 47 bits; the sum of two is 48 bits.
    localparam int SUM_W   = MANT_W + (1 << EXP_W);
    localparam int SHIFT_W = 5;

    // Stream widths, padded to whole bytes.
    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 184;

    // Result of one normalization pass of the shared adder and shifter.
    typedef struct packed {
        logic              ovf;
        logic [EXP_W-1:0]  exp;
        logic [MANT_W-1:0] mant;
    } norm_res_t;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_PSTART = 6'b000010,
        ST_PWAIT  = 6'b000100,
        ST_BSTART = 6'b001000,
        ST_BWAIT  = 6'b010000,
        ST_OUT    = 6'b100000
    } state_t;

endpackage

/* hdl/flow_record_merge_top.sv */
// Flow record accumulator. The block holds one flow record: first and last
// timestamps (seconds and microseconds) and packet and byte counts, each a
// 32-bit mantissa with a 4-bit power-of-two exponent. An item with mode 0
// replaces the record; an item with mode 1 merges into it, keeping the
// earlier first time, the later last time, and adding the expanded counts,
// then normalizing each sum back to 32 bits. A count whose exponent would
// exceed 15 is stored and emitted as zero with its overflow flag set. One
// result item, the record as it stands afterwards, follows every input item.
// The block works on one item at a time: s_tready is high only while idle.
// A load item goes from acceptance straight to the output state. A merge
// item passes through PSTART, PWAIT, BSTART, BWAIT and OUT; each wait state
// holds until the right shifts (0 to 16 each) that the packet or byte sum
// needs are made. The single shared adder and one-bit shifter first normalizes
// the packet sum and then the byte sum, one bit per cycle. A stalled m_tready
// holds the result in the output state.
module flow_record_merge_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // Fields from bit 0 up: first_sec, first_usec, last_sec, last_usec,
    // packet_mantissa, packet_exponent, byte_mantissa, byte_exponent.
    input  logic [frm_pkg::IN_DATA_W-1:0]     s_tdata,
    // Fields from bit 0 up: mode.
    input  logic [0:0]                        s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // Fields from bit 0 up: out_first_sec, out_first_usec, out_last_sec,
    // out_last_usec, out_packet_mantissa, out_packet_exponent,
    // out_byte_mantissa, out_byte_exponent, packet_overflow, byte_overflow,
    // then zero padding.
    output logic [frm_pkg::OUT_DATA_W-1:0]    m_tdata
);

    frm_pkg::state_t state_reg, state_next;

    // Captured merge operands.
    logic [frm_pkg::SEC_W-1:0]  in_fs_reg, in_ls_reg;
    logic [frm_pkg::USEC_W-1:0] in_fu_reg, in_lu_reg;
    logic [frm_pkg::MANT_W-1:0] in_pm_reg, in_bm_reg;
    logic [frm_pkg::EXP_W-1:0]  in_pe_reg, in_be_reg;
    logic                       mode_reg, mode_next;

    // The accumulated record.
    logic [frm_pkg::SEC_W-1:0]  acc_fs_reg, acc_fs_next, acc_ls_reg, acc_ls_next;
    logic [frm_pkg::USEC_W-1:0] acc_fu_reg, acc_fu_next, acc_lu_reg, acc_lu_next;
    logic [frm_pkg::MANT_W-1:0] acc_pm_reg, acc_pm_next, acc_bm_reg, acc_bm_next;
    logic [frm_pkg::EXP_W-1:0]  acc_pe_reg, acc_pe_next, acc_be_reg, acc_be_next;
    logic                       pov_reg, pov_next, bov_reg, bov_next;

    logic                       s_fire;
    logic                       first_earlier, last_later;

    // Shared normalizer operands and result.
    logic                       norm_start;
    logic [frm_pkg::MANT_W-1:0] norm_a_mant, norm_b_mant;
    logic [frm_pkg::EXP_W-1:0]  norm_a_exp, norm_b_exp;
    logic                       norm_done;
    frm_pkg::norm_res_t         norm_res;

    assign s_tready = (state_reg == frm_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == frm_pkg::ST_OUT);
    assign s_fire   = s_tvalid && s_tready;

    // Times compare as (seconds, microseconds) pairs; ties keep the stored time.
    assign first_earlier = (in_fs_reg < acc_fs_reg)
                        || ((in_fs_reg == acc_fs_reg) && (in_fu_reg < acc_fu_reg));
    assign last_later    = (in_ls_reg > acc_ls_reg)
                        || ((in_ls_reg == acc_ls_reg) && (in_lu_reg > acc_lu_reg));

    // The packet counts go through the normalizer first, then the byte counts.
    assign norm_start  = (state_reg == frm_pkg::ST_PSTART)
                      || (state_reg == frm_pkg::ST_BSTART);
    assign norm_a_mant = (state_reg == frm_pkg::ST_PSTART) ? acc_pm_reg : acc_bm_reg;
    assign norm_a_exp  = (state_reg == frm_pkg::ST_PSTART) ? acc_pe_reg : acc_be_reg;
    assign norm_b_mant = (state_reg == frm_pkg::ST_PSTART) ? in_pm_reg : in_bm_reg;
    assign norm_b_exp  = (state_reg == frm_pkg::ST_PSTART) ? in_pe_reg : in_be_reg;

    frm_norm u_norm (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (norm_start),
        .a_mant  (norm_a_mant),
        .a_exp   (norm_a_exp),
        .b_mant  (norm_b_mant),
        .b_exp   (norm_b_exp),
        .done    (norm_done),
        .res     (norm_res)
    );

    always_comb begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        acc_fs_next = acc_fs_reg;
        acc_fu_next = acc_fu_reg;
        acc_ls_next = acc_ls_reg;
        acc_lu_next = acc_lu_reg;
        acc_pm_next = acc_pm_reg;
        acc_pe_next = acc_pe_reg;
        acc_bm_next = acc_bm_reg;
        acc_be_next = acc_be_reg;
        pov_next    = pov_reg;
        bov_next    = bov_reg;
        unique case (state_reg)
            frm_pkg::ST_IDLE: begin
                if (s_fire) begin
                    mode_next = s_tuser[0];
                    pov_next  = 1'b0;
                    bov_next  = 1'b0;
                    if (!s_tuser[0]) begin
                        // A load item replaces the record as it stands, unnormalized.
                        acc_fs_next = s_tdata[31:0];
                        acc_fu_next = s_tdata[51:32];
                        acc_ls_next = s_tdata[83:52];
                        acc_lu_next = s_tdata[103:84];
                        acc_pm_next = s_tdata[135:104];
                        acc_pe_next = s_tdata[139:136];
                        acc_bm_next = s_tdata[171:140];
                        acc_be_next = s_tdata[175:172];
                        state_next  = frm_pkg::ST_OUT;
                    end else begin
                        state_next = frm_pkg::ST_PSTART;
                    end
                end
            end
            frm_pkg::ST_PSTART: begin
                if (first_earlier) begin
                    acc_fs_next = in_fs_reg;
                    acc_fu_next = in_fu_reg;
                end
                if (last_later) begin
                    acc_ls_next = in_ls_reg;
                    acc_lu_next = in_lu_reg;
                end
                state_next = frm_pkg::ST_PWAIT;
            end
            frm_pkg::ST_PWAIT: begin
                if (norm_done) begin
                    acc_pm_next = norm_res.mant;
                    acc_pe_next = norm_res.exp;
                    pov_next    = norm_res.ovf;
                    state_next  = frm_pkg::ST_BSTART;
                end
            end
            frm_pkg::ST_BSTART: begin
                state_next = frm_pkg::ST_BWAIT;
            end
            frm_pkg::ST_BWAIT: begin
                if (norm_done) begin
                    acc_bm_next = norm_res.mant;
                    acc_be_next = norm_res.exp;
                    bov_next    = norm_res.ovf;
                    state_next  = frm_pkg::ST_OUT;
                end
            end
            frm_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = frm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = frm_pkg::ST_IDLE;
            end
        endcase
    end

    // Merge operands are held for the whole item; they need no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_fs_reg <= s_tdata[31:0];
            in_fu_reg <= s_tdata[51:32];
            in_ls_reg <= s_tdata[83:52];
            in_lu_reg <= s_tdata[103:84];
            in_pm_reg <= s_tdata[135:104];
            in_pe_reg <= s_tdata[139:136];
            in_bm_reg <= s_tdata[171:140];
            in_be_reg <= s_tdata[175:172];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= frm_pkg::ST_IDLE;
            mode_reg   <= 1'b0;
            acc_fs_reg <= '0;
            acc_fu_reg <= '0;
            acc_ls_reg <= '0;
            acc_lu_reg <= '0;
            acc_pm_reg <= '0;
            acc_pe_reg <= '0;
            acc_bm_reg <= '0;
            acc_be_reg <= '0;
            pov_reg    <= 1'b0;
            bov_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            acc_fs_reg <= acc_fs_next;
            acc_fu_reg <= acc_fu_next;
            acc_ls_reg <= acc_ls_next;
            acc_lu_reg <= acc_lu_next;
            acc_pm_reg <= acc_pm_next;
            acc_pe_reg <= acc_pe_next;
            acc_bm_reg <= acc_bm_next;
            acc_be_reg <= acc_be_next;
            pov_reg    <= pov_next;
            bov_reg    <= bov_next;
        end
    end

    // The result item is the accumulator itself, held stable while in the output state.
    assign m_tdata = {6'b0, bov_reg, pov_reg, acc_be_reg, acc_bm_reg, acc_pe_reg,
                      acc_pm_reg, acc_lu_reg, acc_ls_reg, acc_fu_reg, acc_fs_reg};

`ifndef NO_ASSERTIONS
    // The block never offers a result while it takes a new item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    // Once a result is taken the block is ready for the next item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> s_tready)
        else $error("block not idle after a result was taken");

    // A load item never reports a count overflow.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !mode_reg) |-> (!pov_reg && !bov_reg))
        else $error("overflow flagged on a load item");

    // A merged packet count that was shifted is left with its top mantissa bit set.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && mode_reg && (acc_pe_reg != '0)) |-> acc_pm_reg[frm_pkg::MANT_W-1])
        else $error("packet count not minimally normalized");
`endif

endmodule

/* hdl/frm_norm.sv */
module frm_norm (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [frm_pkg::MANT_W-1:0]  a_mant,
    input  logic [frm_pkg::EXP_W-1:0]   a_exp,
    input  logic [frm_pkg::MANT_W-1:0]  b_mant,
    input  logic [frm_pkg::EXP_W-1:0]   b_exp,
    output logic                        done,
    output frm_pkg::norm_res_t          res
);

    logic [frm_pkg::SUM_W-1:0]   sum_reg, sum_next;
    logic [frm_pkg::SHIFT_W-1:0] shift_reg, shift_next;
    logic                        busy_reg, busy_next;
    logic                        too_wide;

    // The sum still has bits above the 32-bit mantissa.
    assign too_wide = |sum_reg[frm_pkg::SUM_W-1:frm_pkg::MANT_W];

    always_comb begin
        sum_next   = sum_reg;
        shift_next = shift_reg;
        busy_next  = busy_reg;
        if (start) begin
            sum_next   = (frm_pkg::SUM_W'(a_mant) << a_exp)
                       + (frm_pkg::SUM_W'(b_mant) << b_exp);
            shift_next = '0;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            if (too_wide) begin
                sum_next   = sum_reg >> 1;
                shift_next = shift_reg + 1'b1;
            end else begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        sum_reg   <= sum_next;
        shift_reg <= shift_next;
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    assign done = busy_reg && !too_wide;

    // More than fifteen shifts means the exponent does not fit; the count is dropped.
    always_comb begin
        res.ovf  = shift_reg[frm_pkg::SHIFT_W-1];
        res.exp  = res.ovf ? '0 : shift_reg[frm_pkg::EXP_W-1:0];
        res.mant = res.ovf ? '0 : sum_reg[frm_pkg::MANT_W-1:0];
    end

endmodule
